// File: src/ilir_pkg.sv
package ilir_pkg;

    localparam int CAPACITY   = 64;
    localparam int ELEM_WIDTH = 32;
    localparam int POS_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int GROUPS     = CAPACITY / LANES;
    localparam int GROUP_W    = POS_W - LANE_W;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [5:0]  index;
        logic [31:0] value;
    } in_t;

    typedef struct packed {
        logic [31:0] data;
        status_t     status;
        logic [6:0]  count;
    } out_t;

    typedef struct packed {
        cell_op_t                op;
        logic [POS_W-1:0]        target;
        logic [ELEM_WIDTH-1:0]   value;
    } cell_ctrl_t;

endpackage

// File: src/indexed_list_insert_remove_unit.sv
// Ordered list of up to 64 elements of 32 bits with a fill count.
// Command channel: an item (cmd, index, value) is taken at a rising edge
// where start is high and busy is low. Push appends, pop takes off the
// last element, insert places a value at an index below the count and
// moves later elements up, remove returns the element at an index and
// moves later elements down.
// Result channel: done is high for exactly one cycle with result
// (data, status, count); the receiver cannot stall it, so it must take
// the result in that cycle.
// Timing: the accepting edge moves the state to S_EXEC, and the edge
// that leaves S_EXEC raises done and loads the result register. busy is
// high while the state is S_EXEC, so no new item is taken then; a new item
// can be taken in the cycle where the previous result is shown. S_EXEC is
// needed because the read tree registers the lane pick at the accepting
// edge; the group pick then feeds the result register, while the cells shift all elements at once.
// Reset clears the count, the control state and done; element storage
// is not cleared and is only ever returned from positions below the count.
module indexed_list_insert_remove_unit
    import ilir_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  in_t  command,
    output logic busy,
    output logic done,
    output out_t result
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    cell_ctrl_t ctrl_reg, ctrl_next;
    status_t status_reg, status_next;
    logic rd_reg, rd_next;
    logic done_reg;
    out_t result_reg;

    cell_ctrl_t cell_ctrl;
    logic [POS_W-1:0] rd_sel;
    logic [ELEM_WIDTH-1:0] rd_data;
    logic [ELEM_WIDTH-1:0] elem [CAPACITY];
    logic accept;
    logic idx_bad;
    logic full;
    logic empty;

    assign accept  = start && !busy;
    assign idx_bad = {1'b0, command.index} >= fill_reg;
    assign full    = fill_reg == CNT_W'(CAPACITY);
    assign empty   = fill_reg == '0;

    // Decode the command against the current count.
    always_comb
    begin
        fill_next     = fill_reg;
        status_next   = ST_OK;
        rd_next       = 1'b0;
        ctrl_next     = ctrl_reg;
        rd_sel        = command.index;
        if (accept)
        begin
            ctrl_next.op     = OP_HOLD;
            ctrl_next.target = command.index;
            ctrl_next.value  = command.value;
            unique case (command.cmd)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl_next.op     = OP_LOAD;
                        ctrl_next.target = fill_reg[POS_W-1:0];
                        fill_next        = fill_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    rd_sel = POS_W'(fill_reg - CNT_W'(1));
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_next   = 1'b1;
                        fill_next = fill_reg - CNT_W'(1);
                    end
                end
                CMD_INSERT:
                begin
                    if (idx_bad)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl_next.op = OP_SHIFT_UP;
                        fill_next    = fill_reg + CNT_W'(1);
                    end
                end
                CMD_REMOVE:
                begin
                    if (idx_bad)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        ctrl_next.op = OP_SHIFT_DOWN;
                        rd_next      = 1'b1;
                        fill_next    = fill_reg - CNT_W'(1);
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = 1'b0;
        cell_ctrl = ctrl_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cell_ctrl.op = OP_HOLD;
            end
            S_EXEC:
            begin
                busy = 1'b1;
            end
            default:
            begin
                cell_ctrl.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= state_reg == S_EXEC;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_next;
        if (accept)
        begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
        if (state_reg == S_EXEC)
        begin
            result_reg.data   <= rd_reg ? rd_data : '0;
            result_reg.status <= status_reg;
            result_reg.count  <= fill_reg;
        end
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] left_k;
        logic [ELEM_WIDTH-1:0] right_k;

        if (k == 0)
        begin : g_first
            assign left_k = cell_ctrl.value;
        end
        else
        begin : g_mid_l
            assign left_k = elem[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_k = elem[k];
        end
        else
        begin : g_mid_r
            assign right_k = elem[k+1];
        end

        ilir_cell u_cell (
            .clk    (clk),
            .my_pos (POS_W'(k)),
            .ctrl   (cell_ctrl),
            .left   (left_k),
            .right  (right_k),
            .q      (elem[k])
        );
    end

    ilir_read_tree u_read (
        .clk     (clk),
        .capture (accept),
        .sel     (rd_sel),
        .elems   (elem),
        .data    (rd_data)
    );

    assign done   = done_reg;
    assign result = result_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result without a command in execution");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> result.count == CNT_W'(CAPACITY))
        else $error("full status with a count below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |-> result.count == '0)
        else $error("empty status with a nonzero count");

    a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> state_reg == S_IDLE)
        else $error("execution state held for more than one cycle");

endmodule

// File: src/ilir_cell.sv
module ilir_cell
    import ilir_pkg::*;
(
    input  logic                  clk,
    input  logic [POS_W-1:0]      my_pos,
    input  cell_ctrl_t            ctrl,
    input  logic [ELEM_WIDTH-1:0] left,
    input  logic [ELEM_WIDTH-1:0] right,
    output logic [ELEM_WIDTH-1:0] q
);

    logic [ELEM_WIDTH-1:0] q_reg;
    logic [ELEM_WIDTH-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                if (my_pos == ctrl.target)
                begin
                    q_next = ctrl.value;
                end
            end
            OP_SHIFT_UP:
            begin
                if (my_pos > ctrl.target)
                begin
                    q_next = left;
                end
                else if (my_pos == ctrl.target)
                begin
                    q_next = ctrl.value;
                end
            end
            OP_SHIFT_DOWN:
            begin
                if (my_pos >= ctrl.target)
                begin
                    q_next = right;
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// File: src/ilir_read_tree.sv
module ilir_read_tree
    import ilir_pkg::*;
(
    input  logic                  clk,
    input  logic                  capture,
    input  logic [POS_W-1:0]      sel,
    input  logic [ELEM_WIDTH-1:0] elems [CAPACITY],
    output logic [ELEM_WIDTH-1:0] data
);

    // First level picks the lane inside every group and is registered on
    // capture; the second level picks the group from those registers.
    logic [ELEM_WIDTH-1:0] grp_reg [GROUPS];
    logic [GROUP_W-1:0]    grp_sel_reg;

    for (genvar g = 0; g < GROUPS; g++)
    begin : g_group
        always_ff @(posedge clk)
        begin
            if (capture)
            begin
                grp_reg[g] <= elems[{GROUP_W'(g), sel[LANE_W-1:0]}];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            grp_sel_reg <= sel[POS_W-1:LANE_W];
        end
    end

    assign data = grp_reg[grp_sel_reg];

endmodule
